// ===== rtl/kct_pkg.sv =====
`default_nettype none
package kct_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIM = 4;
  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 8;
  localparam int AW = 8;
  localparam int MEM_DEPTH = 152;

  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 8'd1;
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST = 31'd6554;
  localparam logic [CFG_W-1:0] PROC_NOISE_RST = 31'd0;

  // memory map, row-major matrices
  localparam logic [AW-1:0] X_BASE  = 8'd0;
  localparam logic [AW-1:0] XP_BASE = 8'd4;
  localparam logic [AW-1:0] T1_BASE = 8'd8;
  localparam logic [AW-1:0] T2_BASE = 8'd24;
  localparam logic [AW-1:0] P_BASE  = 8'd40;
  localparam logic [AW-1:0] K_BASE  = 8'd56;
  localparam logic [AW-1:0] F_BASE  = 8'd72;
  localparam logic [AW-1:0] FT_BASE = 8'd88;
  localparam logic [AW-1:0] I_BASE  = 8'd104;
  localparam logic [AW-1:0] A_BASE  = 8'd120;

  typedef logic [31:0] word_t;
  typedef logic [DIM-1:0][31:0] vec_t;

  typedef struct packed {
    vec_t est;
    logic fault;
  } res_t;

  typedef enum logic [1:0] {OP_MM, OP_EL, OP_INV, OP_END} op_t;
  typedef enum logic {ASEL_MEM, ASEL_ZIN} asel_t;
  typedef enum logic [1:0] {BSEL_MEM, BSEL_ZERO, BSEL_QALL, BSEL_RDIAG} bsel_t;

  typedef struct packed {
    op_t           op;
    logic [AW-1:0] dbase;
    logic [3:0]    dstr;
    logic [AW-1:0] abase;
    logic [3:0]    astr;
    logic [AW-1:0] bbase;
    logic [3:0]    bstr;
    logic          one_col;
    asel_t         asel;
    bsel_t         bsel;
    logic          sub;
  } instr_t;

  function automatic instr_t mk_ins(input op_t op, input logic [AW-1:0] d,
                                    input int ds, input logic [AW-1:0] a,
                                    input int as, input logic [AW-1:0] b,
                                    input int bs, input int one,
                                    input asel_t asl, input bsel_t bsl, input int sb);
    instr_t t;
    t.op = op;
    t.dbase = d;
    t.dstr = 4'(ds);
    t.abase = a;
    t.astr = 4'(as);
    t.bbase = b;
    t.bstr = 4'(bs);
    t.one_col = (one != 0);
    t.asel = asl;
    t.bsel = bsl;
    t.sub = (sb != 0);
    return t;
  endfunction

  function automatic instr_t prog_rom(input logic [3:0] pc);
    instr_t t;
    case (pc)
      4'd0: t = mk_ins(OP_MM, T1_BASE, 4, F_BASE, 4, P_BASE, 4, 0, ASEL_MEM, BSEL_MEM, 0);
      4'd1: t = mk_ins(OP_MM, T2_BASE, 4, T1_BASE, 4, FT_BASE, 4, 0, ASEL_MEM, BSEL_MEM, 0);
      4'd2: t = mk_ins(OP_EL, P_BASE, 4, T2_BASE, 4, T2_BASE, 4, 0, ASEL_MEM, BSEL_QALL, 0);
      4'd3: t = mk_ins(OP_MM, XP_BASE, 1, F_BASE, 4, X_BASE, 1, 1, ASEL_MEM, BSEL_MEM, 0);
      4'd4: t = mk_ins(OP_EL, X_BASE, 1, XP_BASE, 1, XP_BASE, 1, 1, ASEL_MEM, BSEL_ZERO, 0);
      4'd5: t = mk_ins(OP_EL, A_BASE, 8, P_BASE, 4, P_BASE, 4, 0, ASEL_MEM, BSEL_RDIAG, 0);
      4'd6: t = mk_ins(OP_EL, A_BASE + 8'd4, 8, I_BASE, 4, I_BASE, 4, 0, ASEL_MEM,
                       BSEL_ZERO, 0);
      4'd7: t = mk_ins(OP_INV, A_BASE, 8, A_BASE, 8, A_BASE, 8, 0, ASEL_MEM, BSEL_MEM, 0);
      4'd8: t = mk_ins(OP_MM, K_BASE, 4, P_BASE, 4, A_BASE + 8'd4, 8, 0, ASEL_MEM,
                       BSEL_MEM, 0);
      4'd9: t = mk_ins(OP_EL, T2_BASE, 1, XP_BASE, 1, XP_BASE, 1, 1, ASEL_ZIN, BSEL_MEM, 1);
      4'd10: t = mk_ins(OP_MM, T1_BASE, 1, K_BASE, 4, T2_BASE, 1, 1, ASEL_MEM, BSEL_MEM, 0);
      4'd11: t = mk_ins(OP_EL, X_BASE, 1, XP_BASE, 1, T1_BASE, 1, 1, ASEL_MEM, BSEL_MEM, 0);
      4'd12: t = mk_ins(OP_EL, T1_BASE, 4, I_BASE, 4, K_BASE, 4, 0, ASEL_MEM, BSEL_MEM, 1);
      4'd13: t = mk_ins(OP_MM, T2_BASE, 4, T1_BASE, 4, P_BASE, 4, 0, ASEL_MEM, BSEL_MEM, 0);
      4'd14: t = mk_ins(OP_EL, P_BASE, 4, T2_BASE, 4, T2_BASE, 4, 0, ASEL_MEM, BSEL_ZERO, 0);
      default: t = mk_ins(OP_END, X_BASE, 0, X_BASE, 0, X_BASE, 0, 0, ASEL_MEM, BSEL_ZERO, 0);
    endcase
    return t;
  endfunction

  // reset image: x = 0, P = I, constant F, F^T and I
  function automatic word_t init_word(input logic [AW-1:0] a, input int frac);
    logic [AW-1:0] off;
    logic [1:0] r;
    logic [1:0] c;
    logic hit;
    word_t one;
    one = word_t'(1) << frac;
    hit = 1'b0;
    off = '0;
    if (a >= P_BASE && a < K_BASE) off = a - P_BASE;
    else if (a >= F_BASE && a < FT_BASE) off = a - F_BASE;
    else if (a >= FT_BASE && a < I_BASE) off = a - FT_BASE;
    else if (a >= I_BASE && a < A_BASE) off = a - I_BASE;
    r = off[3:2];
    c = off[1:0];
    if ((a >= P_BASE && a < K_BASE) || (a >= I_BASE && a < A_BASE)) hit = (r == c);
    else if (a >= F_BASE && a < FT_BASE) hit = (r == c) || (!r[1] && c == {1'b1, r[0]});
    else if (a >= FT_BASE && a < I_BASE) hit = (r == c) || (!c[1] && r == {1'b1, c[0]});
    return hit ? one : word_t'(0);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/kct_meas_if.sv =====
`default_nettype none
interface kct_meas_if;
  logic valid;
  logic ready;
  logic signed [31:0] meas_pos_x;
  logic signed [31:0] meas_pos_y;
  logic signed [31:0] meas_vel_x;
  logic signed [31:0] meas_vel_y;
  modport source(output valid, output meas_pos_x, output meas_pos_y, output meas_vel_x,
                 output meas_vel_y, input ready);
  modport sink(input valid, input meas_pos_x, input meas_pos_y, input meas_vel_x,
               input meas_vel_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/kct_est_if.sv =====
`default_nettype none
interface kct_est_if;
  logic valid;
  logic ready;
  logic signed [31:0] est_pos_x;
  logic signed [31:0] est_pos_y;
  logic signed [31:0] est_vel_x;
  logic signed [31:0] est_vel_y;
  logic pivot_fault;
  modport source(output valid, output est_pos_x, output est_pos_y, output est_vel_x,
                 output est_vel_y, output pivot_fault, input ready);
  modport sink(input valid, input est_pos_x, input est_pos_y, input est_vel_x,
               input est_vel_y, input pivot_fault, output ready);
endinterface
`default_nettype wire

// ===== rtl/kct_cfg_if.sv =====
`default_nettype none
interface kct_cfg_if import kct_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/kalman_tracker_2d_const_velocity.sv =====
// run time per measurement is set by the serial divider, whose quotient width grows with FRAC_BITS
//   (32 quotients in the gauss-jordan inverse), and by the read/multiply/accumulate step
//   of the shared mac over the matrix memory
// throughput: one transaction in flight; the next is taken once the result is registered
// reset: synchronous; a pass over all 152 memory words then loads x = 0, P = I and constant tables
//   into the memory before the first measurement is taken
`default_nettype none
module kalman_tracker_2d_const_velocity
  import kct_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  kct_meas_if.sink meas,
  kct_est_if.source est,
  kct_cfg_if.sink cfg
);

  logic [CFG_W-1:0] meas_noise_var;
  logic [CFG_W-1:0] proc_noise_var;
  logic core_idle;
  logic core_done;
  logic hold;
  logic out_valid;
  res_t core_res;
  res_t out_res;
  vec_t z;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_noise_var <= MEAS_NOISE_RST;
      proc_noise_var <= PROC_NOISE_RST;
    end else if (cfg.valid) begin
      if (cfg.index == REG_MEAS_NOISE) meas_noise_var <= cfg.data[CFG_W-1:0];
      else if (cfg.index == REG_PROC_NOISE) proc_noise_var <= cfg.data[CFG_W-1:0];
    end
  end

  assign z = {meas.meas_vel_y, meas.meas_vel_x, meas.meas_pos_y, meas.meas_pos_x};
  assign meas.ready = core_idle;
  assign hold = out_valid && !est.ready;

  kct_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk  (clk),
    .rst  (rst),
    .start(meas.valid && core_idle),
    .z_in (z),
    .r_var(meas_noise_var),
    .q_var(proc_noise_var),
    .hold (hold),
    .idle (core_idle),
    .done (core_done),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_done) begin
      out_valid <= 1'b1;
    end else if (est.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done) out_res <= core_res;
  end

  assign est.valid = out_valid;
  assign est.est_pos_x = out_res.est[0];
  assign est.est_pos_y = out_res.est[1];
  assign est.est_vel_x = out_res.est[2];
  assign est.est_vel_y = out_res.est[3];
  assign est.pivot_fault = out_res.fault;

endmodule
`default_nettype wire

// ===== rtl/kct_div.sv =====
`default_nettype none
module kct_div
  import kct_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t num,
  input  word_t den,
  output logic  done,
  output word_t quo
);

  localparam int NW = 33 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] n;
  logic [NW-1:0] q;
  logic [32:0] rem;
  logic [32:0] rem_sh;
  logic [31:0] mb;
  logic [31:0] ma_in;
  logic [31:0] mb_in;
  logic neg;
  logic busy;
  logic [CW-1:0] cnt;

  assign ma_in = num[31] ? (~num + 32'd1) : num;
  assign mb_in = den[31] ? (~den + 32'd1) : den;
  assign rem_sh = {rem[31:0], n[NW-1]};

  // saturate the magnitude quotient to the signed word range
  always_comb begin
    if (neg) begin
      if (q > NW'(33'h080000000)) quo = 32'h80000000;
      else quo = ~q[31:0] + 32'd1;
    end else begin
      if (q > NW'(32'h7FFFFFFF)) quo = 32'h7FFFFFFF;
      else quo = q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n <= NW'({ma_in, {FRAC_BITS{1'b0}}}) + NW'(mb_in >> 1);
        mb <= mb_in;
        q <= '0;
        rem <= '0;
        neg <= num[31] ^ den[31];
        cnt <= CW'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        n <= n << 1;
        if (rem_sh >= {1'b0, mb}) begin
          rem <= rem_sh - {1'b0, mb};
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kct_core.sv =====
`default_nettype none
module kct_core
  import kct_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  vec_t             z_in,
  input  logic [CFG_W-1:0] r_var,
  input  logic [CFG_W-1:0] q_var,
  input  logic             hold,
  output logic             idle,
  output logic             done,
  output res_t             res
);

  localparam int ACCW = 67 - FRAC_BITS;
  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
  localparam logic signed [ACCW-1:0] SMAX = {{(ACCW-32){1'b0}}, 32'h7FFFFFFF};
  localparam logic signed [ACCW-1:0] SMIN = {{(ACCW-32){1'b1}}, 32'h80000000};

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_FETCH,
    S_M_RD, S_M_MUL, S_M_ACC,
    S_E_RD, S_E_WR,
    S_G_PS_RD, S_G_PS_CHK, S_G_SW_RD, S_G_SW_W1, S_G_SW_W2,
    S_G_PV_RD, S_G_PV_LT, S_G_NM_RD, S_G_NM_ST, S_G_NM_WT,
    S_G_EF_RD, S_G_EF_LT, S_G_EL_RD, S_G_EL_MUL, S_G_EL_WR,
    S_O_RD, S_O_LT0, S_O_LT1, S_O_DONE
  } state_t;

  state_t state;
  logic [3:0] pc;
  logic [1:0] ri;
  logic [2:0] cj;
  logic [1:0] kk;
  logic [1:0] ci;
  logic [1:0] best;
  logic [31:0] bestmag;
  word_t piv;
  word_t fac;
  word_t opa;
  logic signed [63:0] prod;
  logic signed [ACCW-1:0] acc;
  vec_t zr;
  logic [AW-1:0] clr_addr;

  word_t mem [MEM_DEPTH];
  word_t rd_a;
  word_t rd_b;
  logic we;
  logic [AW-1:0] waddr;
  word_t wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;

  logic div_start;
  logic div_done;
  word_t div_q;

  instr_t ins;
  logic [1:0] j;
  logic last_j;
  logic [AW-1:0] m_a_addr;
  logic [AW-1:0] m_b_addr;
  logic [AW-1:0] e_a_addr;
  logic [AW-1:0] e_b_addr;
  logic [AW-1:0] d_addr;
  logic signed [ACCW-1:0] acc_sum;
  logic signed [ACCW-1:0] el_a;
  logic signed [ACCW-1:0] el_b;
  word_t el_res;
  word_t ge_res;
  logic [31:0] ps_mag;
  logic ps_take;
  logic [31:0] bm_new;
  logic [1:0] best_new;
  logic [2:0] r1;
  logic [2:0] r2;

  function automatic logic signed [ACCW-1:0] rnd(input logic signed [63:0] p);
    logic [63:0] m;
    logic [63:0] r;
    m = p[63] ? 64'(-p) : 64'(p);
    r = (m + HALF) >> FRAC_BITS;
    return p[63] ? -$signed(ACCW'(r)) : $signed(ACCW'(r));
  endfunction

  function automatic word_t sat_w(input logic signed [ACCW-1:0] v);
    if (v > SMAX) return 32'h7FFFFFFF;
    if (v < SMIN) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [AW-1:0] gj(input logic [1:0] r, input logic [2:0] c);
    return A_BASE + AW'({r, c});
  endfunction

  kct_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (rd_a),
    .den  (piv),
    .done (div_done),
    .quo  (div_q)
  );

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  assign ins = prog_rom(pc);
  assign j = cj[1:0];
  assign last_j = ins.one_col || (j == 2'd3);
  assign m_a_addr = ins.abase + AW'(ri) * AW'(ins.astr) + AW'(kk);
  assign m_b_addr = ins.bbase + AW'(kk) * AW'(ins.bstr) + AW'(j);
  assign e_a_addr = ins.abase + AW'(ri) * AW'(ins.astr) + AW'(j);
  assign e_b_addr = ins.bbase + AW'(ri) * AW'(ins.bstr) + AW'(j);
  assign d_addr = ins.dbase + AW'(ri) * AW'(ins.dstr) + AW'(j);
  assign acc_sum = acc + rnd(prod);

  always_comb begin
    if (ins.asel == ASEL_ZIN) el_a = ACCW'($signed(zr[ri]));
    else el_a = ACCW'($signed(rd_a));
    case (ins.bsel)
      BSEL_MEM:   el_b = ACCW'($signed(rd_b));
      BSEL_QALL:  el_b = ACCW'({1'b0, q_var});
      BSEL_RDIAG: el_b = (ri == j) ? ACCW'({1'b0, r_var}) : '0;
      default:    el_b = '0;
    endcase
  end

  assign el_res = sat_w(ins.sub ? (el_a - el_b) : (el_a + el_b));
  assign ge_res = sat_w(ACCW'($signed(opa)) - ACCW'($signed(sat_w(rnd(prod)))));

  assign ps_mag = rd_a[31] ? (~rd_a + 32'd1) : rd_a;
  assign ps_take = (ri == ci) || (ps_mag > bestmag);
  assign bm_new = ps_take ? ps_mag : bestmag;
  assign best_new = ps_take ? ri : best;

  // next row to eliminate, skipping the pivot row
  assign r1 = {1'b0, ri} + 3'd1;
  assign r2 = (!r1[2] && r1[1:0] == ci) ? r1 + 3'd1 : r1;

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr_a = '0;
    raddr_b = '0;
    div_start = 1'b0;
    done = 1'b0;
    idle = 1'b0;
    case (state)
      S_CLR: begin
        we = 1'b1;
        waddr = clr_addr;
        wdata = init_word(clr_addr, FRAC_BITS);
      end
      S_IDLE: idle = 1'b1;
      S_M_RD: begin
        raddr_a = m_a_addr;
        raddr_b = m_b_addr;
      end
      S_M_ACC: begin
        if (kk == 2'd3) begin
          we = 1'b1;
          waddr = d_addr;
          wdata = sat_w(acc_sum);
        end
      end
      S_E_RD: begin
        raddr_a = e_a_addr;
        raddr_b = e_b_addr;
      end
      S_E_WR: begin
        we = 1'b1;
        waddr = d_addr;
        wdata = el_res;
      end
      S_G_PS_RD: raddr_a = gj(ri, {1'b0, ci});
      S_G_SW_RD: begin
        raddr_a = gj(ci, cj);
        raddr_b = gj(best, cj);
      end
      S_G_SW_W1: begin
        we = 1'b1;
        waddr = gj(ci, cj);
        wdata = rd_b;
      end
      S_G_SW_W2: begin
        we = 1'b1;
        waddr = gj(best, cj);
        wdata = opa;
      end
      S_G_PV_RD: raddr_a = gj(ci, {1'b0, ci});
      S_G_NM_RD: raddr_a = gj(ci, cj);
      S_G_NM_ST: div_start = 1'b1;
      S_G_NM_WT: begin
        if (div_done) begin
          we = 1'b1;
          waddr = gj(ci, cj);
          wdata = div_q;
        end
      end
      S_G_EF_RD: raddr_a = gj(ri, {1'b0, ci});
      S_G_EL_RD: begin
        raddr_a = gj(ri, cj);
        raddr_b = gj(ci, cj);
      end
      S_G_EL_WR: begin
        we = 1'b1;
        waddr = gj(ri, cj);
        wdata = ge_res;
      end
      S_O_RD: begin
        raddr_a = X_BASE;
        raddr_b = X_BASE + AW'(1);
      end
      S_O_LT0: begin
        raddr_a = X_BASE + AW'(2);
        raddr_b = X_BASE + AW'(3);
      end
      S_O_DONE: done = !hold;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      pc <= '0;
      ri <= '0;
      cj <= '0;
      kk <= '0;
      ci <= '0;
      res.fault <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MEM_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            zr <= z_in;
            res.fault <= 1'b0;
            pc <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          ri <= '0;
          cj <= '0;
          kk <= '0;
          ci <= '0;
          acc <= '0;
          case (ins.op)
            OP_MM:   state <= S_M_RD;
            OP_EL:   state <= S_E_RD;
            OP_INV:  state <= S_G_PS_RD;
            default: state <= S_O_RD;
          endcase
        end
        S_M_RD: state <= S_M_MUL;
        S_M_MUL: begin
          prod <= $signed(rd_a) * $signed(rd_b);
          state <= S_M_ACC;
        end
        S_M_ACC: begin
          state <= S_M_RD;
          if (kk == 2'd3) begin
            acc <= '0;
            kk <= '0;
            if (last_j) begin
              cj <= '0;
              if (ri == 2'd3) begin
                pc <= pc + 4'd1;
                state <= S_FETCH;
              end else begin
                ri <= ri + 2'd1;
              end
            end else begin
              cj <= cj + 3'd1;
            end
          end else begin
            acc <= acc_sum;
            kk <= kk + 2'd1;
          end
        end
        S_E_RD: state <= S_E_WR;
        S_E_WR: begin
          state <= S_E_RD;
          if (last_j) begin
            cj <= '0;
            if (ri == 2'd3) begin
              pc <= pc + 4'd1;
              state <= S_FETCH;
            end else begin
              ri <= ri + 2'd1;
            end
          end else begin
            cj <= cj + 3'd1;
          end
        end
        S_G_PS_RD: state <= S_G_PS_CHK;
        S_G_PS_CHK: begin
          best <= best_new;
          bestmag <= bm_new;
          cj <= '0;
          if (ri == 2'd3) begin
            if (bm_new == 32'd0) begin
              res.fault <= 1'b1;
              state <= S_O_RD;
            end else if (best_new != ci) begin
              state <= S_G_SW_RD;
            end else begin
              state <= S_G_PV_RD;
            end
          end else begin
            ri <= ri + 2'd1;
            state <= S_G_PS_RD;
          end
        end
        S_G_SW_RD: state <= S_G_SW_W1;
        S_G_SW_W1: begin
          opa <= rd_a;
          state <= S_G_SW_W2;
        end
        S_G_SW_W2: begin
          if (cj == 3'd7) begin
            state <= S_G_PV_RD;
          end else begin
            cj <= cj + 3'd1;
            state <= S_G_SW_RD;
          end
        end
        S_G_PV_RD: state <= S_G_PV_LT;
        S_G_PV_LT: begin
          piv <= rd_a;
          cj <= '0;
          state <= S_G_NM_RD;
        end
        S_G_NM_RD: state <= S_G_NM_ST;
        S_G_NM_ST: state <= S_G_NM_WT;
        S_G_NM_WT: begin
          if (div_done) begin
            if (cj == 3'd7) begin
              ri <= (ci == 2'd0) ? 2'd1 : 2'd0;
              state <= S_G_EF_RD;
            end else begin
              cj <= cj + 3'd1;
              state <= S_G_NM_RD;
            end
          end
        end
        S_G_EF_RD: state <= S_G_EF_LT;
        S_G_EF_LT: begin
          fac <= rd_a;
          cj <= '0;
          state <= S_G_EL_RD;
        end
        S_G_EL_RD: state <= S_G_EL_MUL;
        S_G_EL_MUL: begin
          prod <= $signed(fac) * $signed(rd_b);
          opa <= rd_a;
          state <= S_G_EL_WR;
        end
        S_G_EL_WR: begin
          if (cj == 3'd7) begin
            cj <= '0;
            if (r2[2]) begin
              if (ci == 2'd3) begin
                pc <= pc + 4'd1;
                state <= S_FETCH;
              end else begin
                ci <= ci + 2'd1;
                ri <= ci + 2'd1;
                state <= S_G_PS_RD;
              end
            end else begin
              ri <= r2[1:0];
              state <= S_G_EF_RD;
            end
          end else begin
            cj <= cj + 3'd1;
            state <= S_G_EL_RD;
          end
        end
        S_O_RD: state <= S_O_LT0;
        S_O_LT0: begin
          res.est[0] <= rd_a;
          res.est[1] <= rd_b;
          state <= S_O_LT1;
        end
        S_O_LT1: begin
          res.est[2] <= rd_a;
          res.est[3] <= rd_b;
          state <= S_O_DONE;
        end
        S_O_DONE: begin
          if (!hold) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_kalman_tracker_2d_const_velocity.sv =====
`timescale 1ns / 1ps
module tb_kalman_tracker_2d_const_velocity;
  import kct_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = longint'(1) << FB;
  localparam longint MAXW = 64'sd2147483647;
  localparam longint MINW = -64'sd2147483648;
  localparam int RAND_PER_PHASE = 195;

  typedef struct packed {
    logic [3:0][31:0] est;
    logic fault;
  } est_t;

  typedef struct packed {
    logic [3:0][31:0] meas;
    logic typed;
    est_t want;
  } row_t;

  typedef longint mat_t[4][4];

  logic clk;
  logic rst;

  kct_meas_if meas ();
  kct_est_if est ();
  kct_cfg_if cfg ();

  kalman_tracker_2d_const_velocity u_dut (
    .clk(clk),
    .rst(rst),
    .meas(meas.sink),
    .est(est.source),
    .cfg(cfg.sink)
  );

  longint trk_x[4];
  longint trk_p[4][4];
  longint r_var;
  longint q_var;
  est_t est_q[$];
  int n_err;
  int n_res;
  int n_fault;
  int n_items;

  always #6 clk = ~clk;

  function automatic longint sat32(longint v);
    if (v > MAXW) return MAXW;
    if (v < MINW) return MINW;
    return v;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint fx_prod(longint a, longint b);
    longint p;
    longint unsigned r;
    p = a * b;
    r = (mag(p) + (longint'(1) << (FB - 1))) >> FB;
    return p < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    longint unsigned mb;
    longint unsigned q;
    longint r;
    mb = mag(b);
    q = ((mag(a) << FB) + mb / 2) / mb;
    if (q > (longint'(1) << 40)) q = longint'(1) << 40;
    r = longint'(q);
    return sat32(((a < 0) != (b < 0)) ? -r : r);
  endfunction

  task automatic mat_prod(input mat_t a, input mat_t b, output mat_t c);
    longint acc;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += fx_prod(a[i][k], b[k][j]);
        c[i][j] = sat32(acc);
      end
  endtask

  task automatic gauss_jordan(input mat_t s, output mat_t inv, output bit ok);
    longint a[4][8];
    longint t;
    longint p;
    longint f;
    int best;
    ok = 1;
    for (int i = 0; i < 4; i++)
      for (int c = 0; c < 4; c++) begin
        a[i][c] = s[i][c];
        a[i][c+4] = (i == c) ? ONE : 0;
      end
    for (int i = 0; i < 4 && ok; i++) begin
      best = i;
      for (int r = i + 1; r < 4; r++)
        if (mag(a[r][i]) > mag(a[best][i])) best = r;
      if (a[best][i] == 0) ok = 0;
      else begin
        for (int c = 0; c < 8; c++) begin
          t = a[i][c];
          a[i][c] = a[best][c];
          a[best][c] = t;
        end
        p = a[i][i];
        for (int c = 0; c < 8; c++) a[i][c] = fx_div(a[i][c], p);
        for (int r = 0; r < 4; r++)
          if (r != i) begin
            f = a[r][i];
            for (int c = 0; c < 8; c++) a[r][c] = sat32(a[r][c] - sat32(fx_prod(f, a[i][c])));
          end
      end
    end
    for (int i = 0; i < 4; i++)
      for (int c = 0; c < 4; c++) inv[i][c] = a[i][c+4];
  endtask

  // one predict + update of the tracker (update skipped on a pivot fault), returns the estimate it produces
  task automatic track_step(input logic [3:0][31:0] m, output est_t res);
    mat_t f, ft, t1, t2, sinv, kg;
    longint z[4], xp[4], v[4];
    longint acc;
    bit ok;
    for (int i = 0; i < 4; i++) begin
      z[i] = longint'(signed'(m[i]));
      for (int j = 0; j < 4; j++)
        f[i][j] = (i == j || (i < 2 && j == i + 2)) ? ONE : 0;
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) ft[i][j] = f[j][i];
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int j = 0; j < 4; j++) acc += fx_prod(f[i][j], trk_x[j]);
      xp[i] = sat32(acc);
    end
    mat_prod(f, trk_p, t1);
    mat_prod(t1, ft, t2);
    for (int i = 0; i < 4; i++) begin
      trk_x[i] = xp[i];
      for (int j = 0; j < 4; j++) trk_p[i][j] = sat32(t2[i][j] + q_var);
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) t1[i][j] = sat32(trk_p[i][j] + (i == j ? r_var : 0));
    gauss_jordan(t1, sinv, ok);
    if (ok) begin
      mat_prod(trk_p, sinv, kg);
      for (int i = 0; i < 4; i++) v[i] = sat32(z[i] - xp[i]);
      for (int i = 0; i < 4; i++) begin
        acc = 0;
        for (int j = 0; j < 4; j++) acc += fx_prod(kg[i][j], v[j]);
        trk_x[i] = sat32(xp[i] + sat32(acc));
      end
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++) t1[i][j] = sat32((i == j ? ONE : 0) - kg[i][j]);
      mat_prod(t1, trk_p, t2);
      trk_p = t2;
    end
    for (int i = 0; i < 4; i++) res.est[i] = trk_x[i][31:0];
    res.fault = !ok;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s at result %0d: got %h expected %h", what, n_res, got, want);
    n_err++;
  endtask

  // sender: bursts of transactions with random gaps
  int burst_left;

  task automatic send_meas(input logic [3:0][31:0] m, input bit typed, input est_t want);
    est_t res;
    if (burst_left == 0) begin
      meas.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end else burst_left--;
    meas.valid <= 1'b1;
    meas.meas_pos_x <= m[0];
    meas.meas_pos_y <= m[1];
    meas.meas_vel_x <= m[2];
    meas.meas_vel_y <= m[3];
    do @(posedge clk); while (!meas.ready);
    track_step(m, res);
    est_q.push_back(typed ? want : res);
    n_items++;
  endtask

  task automatic drain();
    meas.valid <= 1'b0;
    burst_left = 0;
    while (est_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_MEAS_NOISE) r_var = longint'(data[30:0]);
    else if (idx == REG_PROC_NOISE) q_var = longint'(data[30:0]);
    @(posedge clk);
  endtask

  // receiver with its own stall pattern
  int stall_mode;
  int stall_cnt;

  always @(posedge clk) begin
    est_t got;
    est_t want;
    if (!rst && est.valid && est.ready) begin
      n_res++;
      if (est_q.size() == 0) begin
        $display("unexpected result transaction %0d", n_res);
        n_err++;
      end else begin
        want = est_q.pop_front();
        got.est = {est.est_vel_y, est.est_vel_x, est.est_pos_y, est.est_pos_x};
        got.fault = est.pivot_fault;
        if (want.fault) n_fault++;
        if (got.est[0] !== want.est[0]) report("est_pos_x", got.est[0], want.est[0]);
        if (got.est[1] !== want.est[1]) report("est_pos_y", got.est[1], want.est[1]);
        if (got.est[2] !== want.est[2]) report("est_vel_x", got.est[2], want.est[2]);
        if (got.est[3] !== want.est[3]) report("est_vel_y", got.est[3], want.est[3]);
        if (got.fault !== want.fault) report("pivot_fault", 32'(got.fault), 32'(want.fault));
      end
    end
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt = $urandom_range(50, 4000);
    end else stall_cnt--;
    case (stall_mode)
      0: est.ready <= 1'b1;
      1: est.ready <= ($urandom_range(0, 3) != 0);
      2: est.ready <= stall_cnt[3];
      default: est.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [31:0] pick_word(input int kind);
    case (kind)
      0: return $urandom();
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'(signed'($urandom_range(0, 8)) - 4);
      default: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
    endcase
  endfunction

  row_t dir_rows[12];
  longint tx, ty, tvx, tvy;

  task automatic random_phase(input int n);
    logic [3:0][31:0] m;
    est_t none;
    none = '0;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 2) begin
        for (int i = 0; i < 4; i++) m[i] = pick_word($urandom_range(0, 4));
      end else begin
        // target moving at steady velocity, noisy sensor
        if ($urandom_range(0, 49) == 0) begin
          tvx = longint'(signed'($urandom_range(0, 32'h000a_0000))) - 64'sh0005_0000;
          tvy = longint'(signed'($urandom_range(0, 32'h000a_0000))) - 64'sh0005_0000;
        end
        tx = sat32(tx + tvx);
        ty = sat32(ty + tvy);
        m[0] = 32'(sat32(tx + longint'($urandom_range(0, 32'h0002_0000)) - 64'sh0001_0000));
        m[1] = 32'(sat32(ty + longint'($urandom_range(0, 32'h0002_0000)) - 64'sh0001_0000));
        m[2] = 32'(sat32(tvx + longint'($urandom_range(0, 32'h0000_8000)) - 64'sh0000_4000));
        m[3] = 32'(sat32(tvy + longint'($urandom_range(0, 32'h0000_8000)) - 64'sh0000_4000));
      end
      send_meas(m, 1'b0, none);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    meas.valid <= 1'b0;
    meas.meas_pos_x <= '0;
    meas.meas_pos_y <= '0;
    meas.meas_vel_x <= '0;
    meas.meas_vel_y <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    n_err = 0;
    n_res = 0;
    n_fault = 0;
    n_items = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_cnt = 0;
    tx = 0;
    ty = 0;
    tvx = 64'sh0001_8000;
    tvy = -64'sh0000_c000;
    for (int i = 0; i < 4; i++) begin
      trk_x[i] = 0;
      for (int j = 0; j < 4; j++) trk_p[i][j] = (i == j) ? ONE : 0;
    end
    r_var = longint'(MEAS_NOISE_RST);
    q_var = longint'(PROC_NOISE_RST);

    // zero measurement from reset state gives a zero estimate
    dir_rows[0] = '{meas: '0, typed: 1'b1, want: '0};
    dir_rows[1] = '{meas: {4{32'h7fff_ffff}}, typed: 1'b0, want: '0};
    dir_rows[2] = '{meas: {4{32'h8000_0000}}, typed: 1'b0, want: '0};
    dir_rows[3] = '{meas: {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
                    typed: 1'b0, want: '0};
    dir_rows[4] = '{meas: {32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff},
                    typed: 1'b0, want: '0};
    dir_rows[5] = '{meas: {4{32'h0001_0000}}, typed: 1'b0, want: '0};
    dir_rows[6] = '{meas: {4{32'haaaa_aaaa}}, typed: 1'b0, want: '0};
    dir_rows[7] = '{meas: {4{32'h5555_5555}}, typed: 1'b0, want: '0};
    dir_rows[8] = '{meas: '0, typed: 1'b0, want: '0};
    dir_rows[9] = '{meas: {32'h0000_8000, 32'hffff_8000, 32'h0000_7fff, 32'hffff_8001},
                    typed: 1'b0, want: '0};
    dir_rows[10] = '{meas: {32'h0100_0000, 32'hff00_0000, 32'h0000_0100, 32'hffff_ff00},
                     typed: 1'b0, want: '0};
    dir_rows[11] = '{meas: '0, typed: 1'b0, want: '0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_meas(dir_rows[i].meas, dir_rows[i].typed, dir_rows[i].want);
    random_phase(RAND_PER_PHASE);
    drain();

    // zero noise: degenerate innovation and pivot fault paths
    write_reg(REG_MEAS_NOISE, 32'h0000_0000);
    write_reg(REG_PROC_NOISE, 32'h0000_0000);
    write_reg(8'd5, 32'h1234_5678);
    random_phase(RAND_PER_PHASE);
    drain();

    write_reg(REG_MEAS_NOISE, 32'h7fff_ffff);
    write_reg(REG_PROC_NOISE, 32'h7fff_ffff);
    send_meas({4{32'h7fff_ffff}}, 1'b0, '0);
    send_meas({4{32'h8000_0000}}, 1'b0, '0);
    random_phase(RAND_PER_PHASE / 2);
    drain();

    // top bit of the data is dropped
    write_reg(REG_MEAS_NOISE, 32'h8001_0000);
    write_reg(REG_PROC_NOISE, 32'h8000_0100);
    random_phase(RAND_PER_PHASE);
    drain();

    write_reg(REG_MEAS_NOISE, $urandom_range(1, 32'h0004_0000));
    write_reg(REG_PROC_NOISE, $urandom_range(0, 32'h0000_1000));
    random_phase(RAND_PER_PHASE);
    drain();

    $display("covered %0d measurements over 5 noise settings, %0d skipped updates",
             n_items, n_fault);
    $display("checked %0d estimates, %0d mismatches", n_res, n_err);
    if (n_err == 0 && est_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #300000000;
    $display("timeout with %0d results outstanding", est_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
